### hdl/itda_pkg.sv
// shared types, constants and a sizing function for the decimal text converter
package itda_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    localparam longint unsigned RADIX = 64'd10;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture a new value
        logic conv;   // four shift-and-adjust steps
        logic scan;   // find the leading nonzero digit
        logic sign;   // load a minus sign into the output register
        logic digit;  // load the current digit into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic neg;
        logic idx_zero;
        logic can_emit;
    } t_status;

    // decimal digits needed for the largest magnitude, 2**(width-1)
    function automatic int dec_digits(input int width);
        longint unsigned v;
        int n;
        v = 64'd1 << (width - 1);
        n = 0;
        while (v != 64'd0) begin
            v = v / RADIX;
            n++;
        end
        return n;
    endfunction

endpackage

### hdl/itda_if.sv
// valid/ready channel interfaces for the input value and the output characters
interface itda_in_if #(
    parameter int WIDTH = itda_pkg::VALUE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

### hdl/itda_ctrl.sv
// controller state machine: sequences load, conversion, scan and emission
module itda_ctrl #(
    parameter int VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  itda_pkg::t_status i_status,
    output itda_pkg::t_cmd    o_cmd
);
    import itda_pkg::*;

    localparam int STEPS  = (VALUE_WIDTH + 3) / 4;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = i_status.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (i_status.can_emit) begin
                    o_cmd.sign = 1'b1;
                    n_state    = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_status.can_emit) begin
                    o_cmd.digit = 1'b1;
                    if (i_status.idx_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

### hdl/itda_dp.sv
// datapath: magnitude, shift-add-3 bcd conversion, digit index and output register
module itda_dp #(
    parameter int VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  itda_pkg::t_cmd         i_cmd,
    output itda_pkg::t_status      o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_char_code,
    output logic                   o_last
);
    import itda_pkg::*;

    localparam int STEPS  = (VALUE_WIDTH + 3) / 4;
    localparam int SH_W   = STEPS * 4;
    localparam int DIGITS = dec_digits(VALUE_WIDTH);
    localparam int BCD_W  = DIGITS * 4;
    localparam int IDX_W  = $clog2(DIGITS);

    logic [SH_W-1:0]  r_shift, n_shift;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic             r_neg, n_neg;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_char, n_char;
    logic             r_last, n_last;

    logic [VALUE_WIDTH-1:0] mag;
    logic [BCD_W-1:0]       bcd_step;
    logic [IDX_W-1:0]       scan_idx;
    logic [3:0]             cur_digit;
    logic                   can_emit;

    // two's complement magnitude, unsigned so the most negative value fits
    assign mag = i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;

    // four double-dabble steps, most significant bits first
    always_comb begin
        bcd_step = r_bcd;
        for (int b = 0; b < 4; b++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (bcd_step[d*4 +: 4] >= 4'd5) begin
                    bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
                end
            end
            bcd_step = {bcd_step[BCD_W-2:0], r_shift[SH_W-1-b]};
        end
    end

    // highest nonzero digit, zero when the whole value is zero
    always_comb begin
        scan_idx = '0;
        for (int k = 0; k < DIGITS; k++) begin
            if (r_bcd[k*4 +: 4] != 4'd0) begin
                scan_idx = IDX_W'(k);
            end
        end
    end

    assign cur_digit = r_bcd[{r_idx, 2'b00} +: 4];
    assign can_emit  = !r_out_valid || i_out_ready;

    always_comb begin
        n_shift     = r_shift;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_idx       = r_idx;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.load) begin
            n_shift = SH_W'(mag);
            n_bcd   = '0;
            n_neg   = i_value[VALUE_WIDTH-1];
        end
        if (i_cmd.conv) begin
            n_shift = {r_shift[SH_W-5:0], 4'b0000};
            n_bcd   = bcd_step;
        end
        if (i_cmd.scan) begin
            n_idx = scan_idx;
        end
        if (i_cmd.sign) begin
            n_char      = CHAR_MINUS;
            n_last      = 1'b0;
            n_out_valid = 1'b1;
        end
        if (i_cmd.digit) begin
            n_char      = CHAR_ZERO + {4'b0000, cur_digit};
            n_last      = (r_idx == '0);
            n_out_valid = 1'b1;
            n_idx       = r_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_neg   <= n_neg;
        r_idx   <= n_idx;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_status.neg      = r_neg;
    assign o_status.idx_zero = (r_idx == '0);
    assign o_status.can_emit = can_emit;
    assign o_out_valid       = r_out_valid;
    assign o_char_code       = r_char;
    assign o_last            = r_last;

endmodule

### hdl/int_to_decimal_ascii_core.sv
// top level of the signed binary to decimal ascii text converter
//
// input channel i_in: one word per number, a signed VALUE_WIDTH-bit value
// output channel o_out: one word per character, most significant first;
//   a minus sign leads a negative number, zero gives a single '0', leading
//   zeros never appear, and last marks the final character of each number
// conversion: the value is loaded on the accepting edge, then a shift-add-3
//   converter handles four bits a cycle until the whole value is shifted in,
//   a scan step finds the leading digit, and then one character a cycle
//   enters the output register while o_out is not stalled
// a new number is taken only once the final character of the previous one
//   has entered the output register, as the conversion register and the
//   single output register serve one number at a time
// i_in.ready is high only while the converter is free; the next number
//   is taken while the final character still waits in the output register
// reset (i_rst_n low, synchronous) empties the output register and returns
//   the controller to idle; no memory needs clearing
// a stall on o_out holds the current character and pauses the sequencer
module int_to_decimal_ascii_core #(
    parameter int VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    itda_in_if.sink  i_in,
    itda_out_if.source o_out
);
    import itda_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: load, convert, scan, then sign and digits
    itda_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // conversion registers and the output word register
    itda_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_in.value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_char_code (o_out.char_code),
        .o_last      (o_out.last)
    );

`ifndef SYNTHESIS
    // every character is a minus sign or a decimal digit
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.char_code == CHAR_MINUS) ||
                        ((o_out.char_code >= CHAR_ZERO) &&
                         (o_out.char_code <= (CHAR_ZERO + 8'd9))))
        else $error("output character outside minus and digits");

    // a minus sign never ends a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.char_code == CHAR_MINUS)) |-> !o_out.last)
        else $error("minus sign flagged as last character");

    // the converter is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready while a conversion runs");

    // the first character after an accept is not emitted on the next edge
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !o_out.valid) |=> !o_out.valid)
        else $error("character appeared before conversion finished");
`endif

endmodule
